/* rtl/core/hrlt_pkg.sv */
package hrlt_pkg;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] line_byte;
    logic       start_line;
  } in_t;

  // Result transfer payload
  typedef struct packed {
    logic [2:0] field_kind;
    logic [7:0] byte_out;
    logic [2:0] param_number;
    logic [1:0] method_code;
    logic       method_done;
    logic       param_overflow;
  } out_t;

  // Parse phase of the request line
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_KEY     = 3'd2,
    PH_VALUE   = 3'd3,
    PH_VERSION = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  // Field tags
  localparam logic [2:0] K_METHOD  = 3'd0;
  localparam logic [2:0] K_PATH    = 3'd1;
  localparam logic [2:0] K_KEY     = 3'd2;
  localparam logic [2:0] K_VALUE   = 3'd3;
  localparam logic [2:0] K_VERSION = 3'd4;
  localparam logic [2:0] K_SEP     = 3'd5;
  localparam logic [2:0] K_EOL     = 3'd6;

  // Method codes
  localparam logic [1:0] M_UNKNOWN = 2'd0;
  localparam logic [1:0] M_GET     = 2'd1;
  localparam logic [1:0] M_POST    = 2'd2;

  // Delimiter characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Letters of "GET"
  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letters of "POST"
  function automatic logic [7:0] post_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h50;
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/hrlt_core.sv */
module hrlt_core #(
  parameter int MAX_PARAM_COUNT = 8,
  parameter int METHOD_MAX_LEN  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_fire,
  input  hrlt_pkg::in_t item,
  output logic          res_valid,
  output hrlt_pkg::out_t res
);

  localparam int POS_W = $clog2(METHOD_MAX_LEN + 1);
  localparam int PARAM_LIMIT_I = (MAX_PARAM_COUNT > 8) ? 7 : MAX_PARAM_COUNT - 1;
  localparam logic [2:0] PARAM_LIMIT = 3'(PARAM_LIMIT_I);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(METHOD_MAX_LEN);

  hrlt_pkg::phase_t phase_r, phase_nxt, ph_cur;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [1:0]       cand_r, cand_nxt, cand_cur;
  logic [2:0]       pcnt_r, pcnt_nxt, pcnt_cur;
  logic             ovf_r, ovf_nxt, ovf_cur;
  logic [7:0]       b;
  logic [2:0]       kind;
  logic [1:0]       code;
  logic             done;

  assign b = item.line_byte;

  // Start of a new request restarts the parse before the byte is handled
  always_comb begin
    if (item.start_line) begin
      ph_cur   = hrlt_pkg::PH_METHOD;
      pos_cur  = '0;
      cand_cur = 2'b11;
      pcnt_cur = '0;
      ovf_cur  = 1'b0;
    end else begin
      ph_cur   = phase_r;
      pos_cur  = pos_r;
      cand_cur = cand_r;
      pcnt_cur = pcnt_r;
      ovf_cur  = ovf_r;
    end
  end

  // Byte classification and phase transition
  always_comb begin
    phase_nxt = ph_cur;
    pos_nxt   = pos_cur;
    cand_nxt  = cand_cur;
    pcnt_nxt  = pcnt_cur;
    ovf_nxt   = ovf_cur;
    kind      = hrlt_pkg::K_METHOD;
    code      = hrlt_pkg::M_UNKNOWN;
    done      = 1'b0;
    res_valid = 1'b1;
    case (ph_cur)
      hrlt_pkg::PH_METHOD: begin
        if (b == hrlt_pkg::CH_SPACE) begin
          kind = hrlt_pkg::K_SEP;
          done = 1'b1;
          if (cand_cur[0] && pos_cur == POS_W'(3)) begin
            code = hrlt_pkg::M_GET;
          end else if (cand_cur[1] && pos_cur == POS_W'(4)) begin
            code = hrlt_pkg::M_POST;
          end
          phase_nxt = hrlt_pkg::PH_PATH;
        end else if (b == hrlt_pkg::CH_NL) begin
          kind      = hrlt_pkg::K_EOL;
          phase_nxt = hrlt_pkg::PH_DONE;
        end else begin
          kind = hrlt_pkg::K_METHOD;
          if (pos_cur >= POS_MAX) begin
            cand_nxt = 2'b00;
          end else begin
            // candidate survives only while the letter matches its word
            if (pos_cur >= POS_W'(3) || hrlt_pkg::get_char(pos_cur[1:0]) != b) begin
              cand_nxt[0] = 1'b0;
            end
            if (pos_cur >= POS_W'(4) || hrlt_pkg::post_char(pos_cur[1:0]) != b) begin
              cand_nxt[1] = 1'b0;
            end
            pos_nxt = pos_cur + POS_W'(1);
          end
        end
      end
      hrlt_pkg::PH_PATH: begin
        if (b == hrlt_pkg::CH_SPACE) begin
          kind      = hrlt_pkg::K_SEP;
          phase_nxt = hrlt_pkg::PH_VERSION;
        end else if (b == hrlt_pkg::CH_QMARK) begin
          kind      = hrlt_pkg::K_SEP;
          phase_nxt = hrlt_pkg::PH_KEY;
        end else if (b == hrlt_pkg::CH_NL) begin
          kind      = hrlt_pkg::K_EOL;
          phase_nxt = hrlt_pkg::PH_DONE;
        end else begin
          kind = hrlt_pkg::K_PATH;
        end
      end
      hrlt_pkg::PH_KEY, hrlt_pkg::PH_VALUE: begin
        if (b == hrlt_pkg::CH_AMP) begin
          kind      = hrlt_pkg::K_SEP;
          phase_nxt = hrlt_pkg::PH_KEY;
          // parameter number saturates, then flags overflow
          if (pcnt_cur < PARAM_LIMIT) begin
            pcnt_nxt = pcnt_cur + 3'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (b == hrlt_pkg::CH_SPACE) begin
          kind      = hrlt_pkg::K_SEP;
          phase_nxt = hrlt_pkg::PH_VERSION;
        end else if (b == hrlt_pkg::CH_NL) begin
          kind      = hrlt_pkg::K_EOL;
          phase_nxt = hrlt_pkg::PH_DONE;
        end else if (b == hrlt_pkg::CH_EQ && ph_cur == hrlt_pkg::PH_KEY) begin
          kind      = hrlt_pkg::K_SEP;
          phase_nxt = hrlt_pkg::PH_VALUE;
        end else begin
          kind = (ph_cur == hrlt_pkg::PH_KEY) ? hrlt_pkg::K_KEY : hrlt_pkg::K_VALUE;
        end
      end
      hrlt_pkg::PH_VERSION: begin
        if (b == hrlt_pkg::CH_NL) begin
          kind      = hrlt_pkg::K_EOL;
          phase_nxt = hrlt_pkg::PH_DONE;
        end else begin
          kind = hrlt_pkg::K_VERSION;
        end
      end
      default: begin
        // header bytes after the line end: no result
        res_valid = 1'b0;
      end
    endcase
  end

  // Result fields carry the updated counters
  always_comb begin
    res.field_kind     = kind;
    res.byte_out       = b;
    res.param_number   = pcnt_nxt;
    res.method_code    = code;
    res.method_done    = done;
    res.param_overflow = ovf_nxt;
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrlt_pkg::PH_METHOD;
      pos_r   <= '0;
      cand_r  <= 2'b11;
      pcnt_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      pcnt_r  <= pcnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* rtl/core/http_request_line_tokenizer.sv */
// HTTP request line tokenizer.
// Input channel (in_valid, in_stall, in_data): one byte of the request line
// per transfer; in_data.start_line marks the first byte of a new request and
// restarts the parse. Result channel (out_valid, out_stall, out_data): one
// tagged byte per input byte, with parameter number, method code on the
// closing space and a sticky overflow flag. Bytes after the first newline
// give no result until the next start_line.
// A result is registered in the result register, or in the skid register
// while the receiver stalls. Throughput: one byte per cycle when in_stall is
// low; the next parse state is combinational, ahead of the result register.
// A two-entry output buffer (result register plus skid register) lets the
// block take one more byte while a result waits; in_stall rises only when
// that skid entry is occupied, and stays until the receiver takes a result.
// Reset (rst_n low, synchronous) empties the buffer and returns the parse to
// the method phase with both candidate methods live and counters at zero.
module http_request_line_tokenizer #(
  parameter int MAX_PARAM_COUNT = 8,
  parameter int METHOD_MAX_LEN  = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hrlt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hrlt_pkg::out_t out_data
);

  logic           in_fire;
  logic           res_valid;
  hrlt_pkg::out_t res;
  logic           new_res;
  logic           out_valid_r, out_valid_nxt;
  hrlt_pkg::out_t out_data_r, out_data_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  hrlt_pkg::out_t skid_data_r, skid_data_nxt;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign new_res  = in_fire && res_valid;

  hrlt_core #(
    .MAX_PARAM_COUNT(MAX_PARAM_COUNT),
    .METHOD_MAX_LEN (METHOD_MAX_LEN)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_fire(in_fire),
    .item     (in_data),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register and skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = new_res;
        out_data_nxt  = res;
      end
    end else if (new_res) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/testbench.sv */
module testbench;

  localparam int PARAM_SLOTS  = 8;
  localparam int METHOD_LIMIT = 7;
  // highest parameter index before the overflow flag takes over
  localparam int PARAM_CAP    = (PARAM_SLOTS > 8) ? 7 : PARAM_SLOTS - 1;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_TOKENS = 250;

  localparam logic [23:0] GET_WORD  = "GET";
  localparam logic [31:0] POST_WORD = "POST";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hrlt_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hrlt_pkg::out_t out_data;

  // Tokenizer state as predicted from the accepted bytes
  hrlt_pkg::phase_t line_phase;
  logic [2:0] method_len;
  logic [1:0] method_live;
  logic [2:0] param_idx;
  logic       param_ovf;

  hrlt_pkg::out_t expected_tokens[$];
  int   tokens_predicted = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // Idling controls
  bit src_gaps_on = 1'b0;
  bit sink_gaps_on = 1'b0;
  int hold_seq = 0;
  int hold_seen = 0;
  int stall_left = 0;
  bit at_line_head = 1'b0;

  http_request_line_tokenizer #(
    .MAX_PARAM_COUNT(PARAM_SLOTS),
    .METHOD_MAX_LEN (METHOD_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Clear the predicted parse state
  function automatic void restart_line();
    line_phase  = hrlt_pkg::PH_METHOD;
    method_len  = '0;
    method_live = 2'b11;
    param_idx   = '0;
    param_ovf   = 1'b0;
  endfunction

  function automatic void step_param();
    if (param_idx < PARAM_CAP) param_idx++;
    else param_ovf = 1'b1;
  endfunction

  // Predict the token for one byte; returns 0 when the byte is dropped
  function automatic bit tokenize(input hrlt_pkg::in_t item, output hrlt_pkg::out_t tok);
    logic [7:0] b;
    logic [2:0] kind;
    logic [1:0] code;
    logic       done;
    b = item.line_byte;
    code = hrlt_pkg::M_UNKNOWN;
    done = 1'b0;
    kind = hrlt_pkg::K_SEP;
    tok = '0;
    if (item.start_line) restart_line();
    case (line_phase)
      hrlt_pkg::PH_METHOD: begin
        if (b == hrlt_pkg::CH_SPACE) begin
          done = 1'b1;
          if (method_live[0] && method_len == 3) code = hrlt_pkg::M_GET;
          else if (method_live[1] && method_len == 4) code = hrlt_pkg::M_POST;
          line_phase = hrlt_pkg::PH_PATH;
        end else if (b == hrlt_pkg::CH_NL) begin
          kind = hrlt_pkg::K_EOL;
          line_phase = hrlt_pkg::PH_DONE;
        end else begin
          kind = hrlt_pkg::K_METHOD;
          if (method_len >= METHOD_LIMIT) begin
            method_live = 2'b00;
          end else begin
            if (method_len >= 3 || GET_WORD[23 - 8 * method_len -: 8] != b)
              method_live[0] = 1'b0;
            if (method_len >= 4 || POST_WORD[31 - 8 * method_len -: 8] != b)
              method_live[1] = 1'b0;
            method_len++;
          end
        end
      end
      hrlt_pkg::PH_PATH: begin
        if (b == hrlt_pkg::CH_SPACE) line_phase = hrlt_pkg::PH_VERSION;
        else if (b == hrlt_pkg::CH_QMARK) line_phase = hrlt_pkg::PH_KEY;
        else if (b == hrlt_pkg::CH_NL) begin
          kind = hrlt_pkg::K_EOL;
          line_phase = hrlt_pkg::PH_DONE;
        end else kind = hrlt_pkg::K_PATH;
      end
      hrlt_pkg::PH_KEY, hrlt_pkg::PH_VALUE: begin
        if (b == hrlt_pkg::CH_AMP) begin
          step_param();
          line_phase = hrlt_pkg::PH_KEY;
        end else if (b == hrlt_pkg::CH_SPACE) line_phase = hrlt_pkg::PH_VERSION;
        else if (b == hrlt_pkg::CH_NL) begin
          kind = hrlt_pkg::K_EOL;
          line_phase = hrlt_pkg::PH_DONE;
        end else if (b == hrlt_pkg::CH_EQ && line_phase == hrlt_pkg::PH_KEY)
          line_phase = hrlt_pkg::PH_VALUE;
        else kind = (line_phase == hrlt_pkg::PH_KEY) ? hrlt_pkg::K_KEY : hrlt_pkg::K_VALUE;
      end
      hrlt_pkg::PH_VERSION: begin
        if (b == hrlt_pkg::CH_NL) begin
          kind = hrlt_pkg::K_EOL;
          line_phase = hrlt_pkg::PH_DONE;
        end else kind = hrlt_pkg::K_VERSION;
      end
      default: return 1'b0;
    endcase
    tok.field_kind     = kind;
    tok.byte_out       = b;
    tok.param_number   = param_idx;
    tok.method_code    = code;
    tok.method_done    = done;
    tok.param_overflow = param_ovf;
    return 1'b1;
  endfunction

  // Compare each result transfer with the oldest expected token
  always @(posedge clk) begin
    hrlt_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d byte %h", out_data.field_kind,
                   out_data.byte_out);
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.field_kind !== want.field_kind ||
            out_data.byte_out !== want.byte_out ||
            out_data.param_number !== want.param_number ||
            out_data.method_code !== want.method_code ||
            out_data.method_done !== want.method_done ||
            out_data.param_overflow !== want.param_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch (exp/got): kind %0d/%0d byte %h/%h param %0d/%0d",
                      " code %0d/%0d done %b/%b ovf %b/%b"},
                     want.field_kind, out_data.field_kind, want.byte_out,
                     out_data.byte_out, want.param_number, out_data.param_number,
                     want.method_code, out_data.method_code, want.method_done,
                     out_data.method_done, want.param_overflow, out_data.param_overflow);
        end
      end
    end
  end

  // Offer one byte and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input bit st);
    hrlt_pkg::in_t  item;
    hrlt_pkg::out_t tok;
    int   gap;
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    item.line_byte  = b;
    item.start_line = st;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (tokenize(item, tok)) begin
      expected_tokens.push_back(tok);
      tokens_predicted++;
    end
  endtask

  task automatic send_text(input string s, input bit st);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], st && i == 0);
  endtask

  // Drop valid before time passes without a transfer
  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random byte that is plain content for the given field
  function automatic logic [7:0] field_byte(input hrlt_pkg::phase_t ph);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == hrlt_pkg::CH_NL ||
               (b == hrlt_pkg::CH_SPACE && ph != hrlt_pkg::PH_VERSION) ||
               (b == hrlt_pkg::CH_QMARK && ph == hrlt_pkg::PH_PATH) ||
               (b == hrlt_pkg::CH_AMP &&
                (ph == hrlt_pkg::PH_KEY || ph == hrlt_pkg::PH_VALUE)) ||
               (b == hrlt_pkg::CH_EQ && ph == hrlt_pkg::PH_KEY));
    return b;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, at_line_head);
    at_line_head = 1'b0;
  endtask

  task automatic put_field(input hrlt_pkg::phase_t ph, input int n);
    for (int i = 0; i < n; i++) put_byte(field_byte(ph));
  endtask

  task automatic put_text(input string s, input int n);
    for (int i = 0; i < n; i++) put_byte(s[i]);
  endtask

  // One request line, mostly well formed, with a tail of header bytes
  task automatic random_request();
    int n;
    int nparams;
    at_line_head = 1'b1;
    if ($urandom_range(0, 11) == 0) begin
      // broken sequence: raw bytes with stray restarts
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_text("GET", 3);
      4, 5, 6:    put_text("POST", 4);
      7:          put_text($urandom_range(0, 1) ? "POSTPO" : "GETGET", $urandom_range(0, 6));
      default:    put_field(hrlt_pkg::PH_METHOD, $urandom_range(0, 10));
    endcase
    if ($urandom_range(0, 19) == 0) begin
      put_byte(hrlt_pkg::CH_NL);
    end else begin
      put_byte(hrlt_pkg::CH_SPACE);
      put_field(hrlt_pkg::PH_PATH, $urandom_range(0, 6));
      if ($urandom_range(0, 19) == 0) begin
        put_byte(hrlt_pkg::CH_NL);
      end else begin
        if ($urandom_range(0, 4) < 3) begin
          put_byte(hrlt_pkg::CH_QMARK);
          nparams = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 11)
                                                : $urandom_range(0, 3);
          for (int i = 0; i < nparams; i++) begin
            if (i > 0) put_byte(hrlt_pkg::CH_AMP);
            put_field(hrlt_pkg::PH_KEY, $urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0) begin
              put_byte(hrlt_pkg::CH_EQ);
              put_field(hrlt_pkg::PH_VALUE, $urandom_range(0, 3));
            end
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          put_byte(hrlt_pkg::CH_SPACE);
          if ($urandom_range(0, 4) != 0) put_text("HTTP/1.1", 8);
          else put_field(hrlt_pkg::PH_VERSION, $urandom_range(0, 6));
        end
        put_byte(hrlt_pkg::CH_NL);
      end
    end
    // header bytes after the line are dropped by the block
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic apply_reset();
    restart_line();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Query with '=' inside a value, a bare key, spaces in the version,
  // dropped header byte, newline in method, extreme bytes, newline in path
  task automatic test_directed_lines();
    send_text("GET ?a=b=&c H x\n", 1'b1);
    send_byte("Z", 1'b0);
    send_text("PO\n", 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_text(" /\n", 1'b0);
  endtask

  task automatic test_random_requests();
    int goal;
    goal = tokens_predicted + RANDOM_TOKENS;
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    while (tokens_predicted < goal) random_request();
  endtask

  // Long receiver hold-off while bytes keep coming: the buffer fills and
  // the input must stall
  task automatic test_output_hold();
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    hold_seq++;
    repeat (3) random_request();
  endtask

  // Sender waits for the block to drain completely before carrying on
  task automatic test_drain_pause();
    quiet_input();
    wait (expected_tokens.size() == 0);
    repeat (2) random_request();
  endtask

  // Back-to-back transfers on both sides to close the run
  task automatic test_steady_stream();
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (8) random_request();
  endtask

  initial begin
    apply_reset();
    test_directed_lines();
    test_random_requests();
    test_output_hold();
    test_drain_pause();
    test_steady_stream();
    quiet_input();
    wait (expected_tokens.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/hrlt_pkg.sv
rtl/core/hrlt_core.sv
rtl/core/http_request_line_tokenizer.sv
verif/testbench.sv
